// File: src/btt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Blank-run-to-tab converter package
// Shared types and constants: character codes, register indexes, the
// sequencer states and the request/response structs of the remainder unit.
// ----------------------------------------------------------------------------
package btt_pkg;

    // Field widths fixed by the interface.
    localparam int BYTE_BITS      = 8;
    localparam int STOP_BITS      = 16;
    localparam int HELD_BITS      = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int STOP_COUNT_BITS = 3;
    localparam int NUM_STOP_REGS  = 4;

    // The remainder unit works on a full 64-bit dividend so that a column
    // left of the last explicit stop wraps exactly as unsigned arithmetic does.
    localparam int DVD_BITS  = 64;
    localparam int STEP_BITS = 7;

    // Character codes.
    localparam logic [BYTE_BITS-1:0] CHAR_TAB   = 8'h09;
    localparam logic [BYTE_BITS-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_BITS-1:0] CHAR_BS    = 8'h08;
    localparam logic [BYTE_BITS-1:0] CHAR_NL    = 8'h0A;
    localparam logic [BYTE_BITS-1:0] CHAR_NUL   = 8'h00;

    // Stop width used when no stops are configured.
    localparam logic [STOP_BITS-1:0] DEFAULT_STOP = 16'd8;

    // Register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CONVERT_ALL = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STOP_COUNT  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STOP_0      = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_EXTEND      = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INCREMENT   = 3'd7;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_END,
        ST_DIV,
        ST_FINISH
    } state_t;

    // Request to the remainder unit.
    typedef struct packed {
        logic                 start;
        logic [DVD_BITS-1:0]  dividend;
        logic [STEP_BITS-1:0] steps;
        logic [STOP_BITS-1:0] divisor;
    } div_req_t;

    // Response from the remainder unit.
    typedef struct packed {
        logic                 done;
        logic [STOP_BITS-1:0] rem;
    } div_rsp_t;

endpackage
`default_nettype wire

// File: src/blank_run_to_tab_converter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Blank-run-to-tab converter
// Holds back runs of spaces in a byte stream and writes a tab where a run
// reaches a tab stop exactly.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the s_ channel (valid/ready). Each request that is not a
//   held space produces one result on the m_ channel: the held run (optional
//   leading tab plus spaces, as lead_tab and held_count) followed by the byte.
//   An end_of_input request flushes the held run with end_of_stream set and
//   restores the line state. Registers are written through cfg_we/cfg_index/
//   cfg_data while no request is in flight.
// Timing:
//   A byte that needs no tab stop goes from the idle state to the finish
//   state, where it is written to the output register, and the sequencer
//   then returns to idle. A blank needs the next stop. With uniform stops
//   that is a modulo in the shared bit-serial remainder unit, over the
//   COLUMN_BITS bits of the column. A stop from the explicit list is found
//   by a scan that steps past each stop passed. A stop past the list comes
//   from the remainder unit, with the extension or, after an end state, the
//   increment; the unit then runs over all 64 dividend bits when the column
//   lies left of the last explicit stop. s_ready is high only while the
//   sequencer is idle.
// Reset and stalls:
//   aresetn clears registers, line state and the output valid flag. A result
//   waits in the output register while m_ready is low; the next request is
//   still accepted and is held at its final step until the register frees.
// ----------------------------------------------------------------------------
module blank_run_to_tab_converter
    import btt_pkg::*;
#(
    parameter int MAX_STOPS   = 4,
    parameter int COLUMN_BITS = 16
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    // Configuration write port
    input  wire                       cfg_we,
    input  wire  [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire  [CFG_DATA_BITS-1:0]  cfg_data,
    // Input channel
    input  wire                       s_valid,
    output logic                      s_ready,
    input  wire  [BYTE_BITS-1:0]      s_in_byte,
    input  wire                       s_end_of_input,
    // Result channel
    output logic                      m_valid,
    input  wire                       m_ready,
    output logic                      m_lead_tab,
    output logic [HELD_BITS-1:0]      m_held_count,
    output logic [BYTE_BITS-1:0]      m_out_byte,
    output logic                      m_byte_valid,
    output logic                      m_end_of_stream
);

    localparam int CW  = COLUMN_BITS;
    localparam int SIW = $clog2(MAX_STOPS + 1);
    localparam int SAW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
    localparam int XW  = ((CW > STOP_BITS) ? CW : STOP_BITS) + 1;
    localparam logic [CW-1:0]        COL_MAX  = '1;
    localparam logic [HELD_BITS-1:0] HELD_MAX = '1;

    // Configuration registers
    logic                       convert_all_reg;
    logic [STOP_COUNT_BITS-1:0] stop_count_reg;
    logic [STOP_BITS-1:0]       stops_reg [MAX_STOPS];
    logic [STOP_BITS-1:0]       extend_reg;
    logic [STOP_BITS-1:0]       increment_reg;

    // Sequencer and request registers
    state_t               state_reg, state_next;
    logic [BYTE_BITS-1:0] byte_reg;
    logic                 end_reg;
    logic                 none_reg;
    logic [XW-1:0]        nxt_reg;
    logic [STOP_BITS-1:0] size_reg;

    // Line state
    logic [CW-1:0]        col_reg, col_next;
    logic [SIW-1:0]       idx_reg, idx_next;
    logic                 conv_reg, conv_next;
    logic                 ab_reg, ab_next;
    logic                 lone_reg, lone_next;
    logic [HELD_BITS-1:0] held_reg, held_next;
    logic                 hft_reg, hft_next;

    // Output register
    logic                 m_valid_reg;
    logic                 lead_reg;
    logic [HELD_BITS-1:0] count_reg;
    logic [BYTE_BITS-1:0] obyte_reg;
    logic                 bvalid_reg;
    logic                 eos_reg;

    // Combinational helpers
    logic [SIW-1:0]       cnt;
    logic [SIW-1:0]       cnt_m1;
    logic [STOP_BITS-1:0] uni;
    logic [SAW-1:0]       rd_addr;
    logic [STOP_BITS-1:0] stop_rd;
    logic                 in_list;
    logic                 scan_hit;
    logic                 in_blank;
    logic                 accept;
    logic                 out_free;
    logic                 commit;
    logic                 emit;
    logic                 res_lead;
    logic [HELD_BITS-1:0] res_cnt;
    logic [BYTE_BITS-1:0] res_byte;
    logic [DVD_BITS-1:0]  diff64;
    logic                 wrapped;
    div_req_t             div_req;
    div_rsp_t             div_rsp;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            convert_all_reg <= 1'b0;
            stop_count_reg  <= '0;
            extend_reg      <= '0;
            increment_reg   <= '0;
            for (int k = 0; k < MAX_STOPS; k++) begin
                stops_reg[k] <= '0;
            end
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_CONVERT_ALL: convert_all_reg <= cfg_data[0];
                CFG_STOP_COUNT:  stop_count_reg  <= cfg_data[STOP_COUNT_BITS-1:0];
                CFG_EXTEND:      extend_reg      <= cfg_data;
                CFG_INCREMENT:   increment_reg   <= cfg_data;
                default: ;
            endcase
            for (int k = 0; k < MAX_STOPS; k++) begin
                if (k < NUM_STOP_REGS && cfg_index == CFG_STOP_0 + CFG_INDEX_BITS'(k)) begin
                    stops_reg[k] <= cfg_data;
                end
            end
        end
    end

    // Stop count in use and the uniform stop width, zero when the list applies.
    always_comb begin
        cnt = (32'(stop_count_reg) > MAX_STOPS) ? SIW'(MAX_STOPS) : SIW'(stop_count_reg);
        if (cnt == '0) begin
            if (extend_reg != '0) begin
                uni = extend_reg;
            end else if (increment_reg != '0) begin
                uni = increment_reg;
            end else begin
                uni = DEFAULT_STOP;
            end
        end else if (cnt == SIW'(1) && extend_reg == '0 && increment_reg == '0) begin
            uni = stops_reg[0];
        end else begin
            uni = '0;
        end
    end

    // Single read port on the stop list: the scan pointer, or the last stop.
    assign cnt_m1   = cnt - SIW'(1);
    assign rd_addr  = (state_reg == ST_END) ? cnt_m1[SAW-1:0] : idx_reg[SAW-1:0];
    assign stop_rd  = stops_reg[rd_addr];
    assign in_list  = idx_reg < cnt;
    assign scan_hit = in_list && (XW'(col_reg) < XW'(stop_rd));

    // Column distance from the last explicit stop, as 64-bit unsigned.
    assign diff64  = DVD_BITS'(col_reg) - DVD_BITS'(stop_rd);
    assign wrapped = XW'(col_reg) < XW'(stop_rd);

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign in_blank = conv_reg && !s_end_of_input
                      && (s_in_byte == CHAR_SPACE || s_in_byte == CHAR_TAB);
    assign out_free = !m_valid_reg || m_ready;
    assign commit   = (state_reg == ST_FINISH) && (!emit || out_free);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!in_blank) begin
                        state_next = ST_FINISH;
                    end else if (uni != '0) begin
                        state_next = ST_DIV;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                priority if (in_list) begin
                    if (scan_hit) begin
                        state_next = ST_FINISH;
                    end
                end else if (extend_reg != '0) begin
                    state_next = ST_DIV;
                end else if (increment_reg != '0) begin
                    state_next = ST_END;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_END: state_next = ST_DIV;
            ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Requests to the remainder unit.
    always_comb begin
        div_req = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && in_blank && uni != '0) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {col_reg, {(DVD_BITS-CW){1'b0}}};
                    div_req.steps    = STEP_BITS'(CW);
                    div_req.divisor  = uni;
                end
            end
            ST_SCAN: begin
                if (!in_list && extend_reg != '0) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {col_reg, {(DVD_BITS-CW){1'b0}}};
                    div_req.steps    = STEP_BITS'(CW);
                    div_req.divisor  = extend_reg;
                end
            end
            ST_END: begin
                div_req.start    = 1'b1;
                div_req.dividend = wrapped ? diff64
                                           : {diff64[CW-1:0], {(DVD_BITS-CW){1'b0}}};
                div_req.steps    = wrapped ? STEP_BITS'(DVD_BITS) : STEP_BITS'(CW);
                div_req.divisor  = increment_reg;
            end
            default: ;
        endcase
    end

    btt_rem_unit u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    // Line state update for the request in hand, and the result it makes.
    always_comb begin
        logic          blank;
        logic [CW-1:0] col1;
        logic          at_stop;
        logic [CW-1:0] col_stop;

        blank    = !end_reg && (byte_reg == CHAR_SPACE || byte_reg == CHAR_TAB);
        col1     = (col_reg == COL_MAX) ? col_reg : col_reg + CW'(1);
        at_stop  = XW'(col1) == nxt_reg;
        col_stop = (nxt_reg > XW'(COL_MAX)) ? COL_MAX : nxt_reg[CW-1:0];

        col_next  = col_reg;
        idx_next  = idx_reg;
        conv_next = conv_reg;
        ab_next   = ab_reg;
        lone_next = lone_reg;
        held_next = held_reg;
        hft_next  = hft_reg;
        emit      = 1'b1;
        res_lead  = 1'b0;
        res_cnt   = '0;
        res_byte  = byte_reg;

        if (conv_reg) begin
            priority if (blank) begin
                if (none_reg) begin
                    // No stop ahead: pass the blank through and stop converting.
                    conv_next = 1'b0;
                end else if (byte_reg == CHAR_TAB) begin
                    col_next  = col_stop;
                    held_next = {{(HELD_BITS-1){1'b0}}, lone_reg};
                    hft_next  = lone_reg;
                    lone_next = 1'b0;
                end else begin
                    col_next = col1;
                    if (!(ab_reg && at_stop)) begin
                        // Space is held back.
                        emit = 1'b0;
                        if (at_stop) begin
                            lone_next = 1'b1;
                        end
                        if (held_reg == '0) begin
                            hft_next = 1'b0;
                        end
                        if (held_reg != HELD_MAX) begin
                            held_next = held_reg + HELD_BITS'(1);
                        end
                        ab_next = 1'b1;
                    end else begin
                        // Run reaches the stop: it becomes a tab.
                        res_byte  = CHAR_TAB;
                        held_next = {{(HELD_BITS-1){1'b0}}, lone_reg};
                        hft_next  = 1'b1;
                    end
                end
            end else if (!end_reg && byte_reg == CHAR_BS) begin
                if (col_reg != '0) begin
                    col_next = col_reg - CW'(1);
                end
                if (idx_reg != '0) begin
                    idx_next = idx_reg - SIW'(1);
                end
            end else if (!end_reg) begin
                col_next = col1;
            end

            if (emit) begin
                // Release the held run in front of the byte.
                if (held_next != '0) begin
                    res_lead  = hft_next || (held_next > HELD_BITS'(1) && lone_next);
                    res_cnt   = held_next;
                    held_next = '0;
                    hft_next  = 1'b0;
                    lone_next = 1'b0;
                end
                ab_next = blank;
                if (!(convert_all_reg || blank)) begin
                    conv_next = 1'b0;
                end
            end
        end

        if (end_reg) begin
            res_byte = CHAR_NUL;
        end

        // A new line or a new stream starts from the reset line state.
        if (emit && (end_reg || byte_reg == CHAR_NL)) begin
            col_next  = '0;
            idx_next  = '0;
            conv_next = 1'b1;
            ab_next   = 1'b1;
            lone_next = 1'b0;
            held_next = '0;
            hft_next  = 1'b0;
        end
    end

    // Sequencer state and line state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            idx_reg   <= '0;
            conv_reg  <= 1'b1;
            ab_reg    <= 1'b1;
            lone_reg  <= 1'b0;
            held_reg  <= '0;
            hft_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (commit) begin
                col_reg  <= col_next;
                idx_reg  <= idx_next;
                conv_reg <= conv_next;
                ab_reg   <= ab_next;
                lone_reg <= lone_next;
                held_reg <= held_next;
                hft_reg  <= hft_next;
            end else if (state_reg == ST_SCAN && in_list && !scan_hit) begin
                idx_reg <= idx_reg + SIW'(1);
            end
        end
    end

    // Request capture and next-stop result.
    always_ff @(posedge aclk) begin
        if (accept) begin
            byte_reg <= s_in_byte;
            end_reg  <= s_end_of_input;
            none_reg <= 1'b0;
        end else if (state_reg == ST_SCAN && !in_list && extend_reg == '0
                     && increment_reg == '0) begin
            none_reg <= 1'b1;
        end
        if (div_req.start) begin
            size_reg <= div_req.divisor;
        end
        if (state_reg == ST_SCAN && scan_hit) begin
            nxt_reg <= XW'(stop_rd);
        end else if (state_reg == ST_DIV && div_rsp.done) begin
            nxt_reg <= XW'(col_reg) + XW'(size_reg) - XW'(div_rsp.rem);
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit && emit) begin
            lead_reg   <= res_lead;
            count_reg  <= res_cnt;
            obyte_reg  <= res_byte;
            bvalid_reg <= !end_reg;
            eos_reg    <= end_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_lead_tab      = lead_reg;
    assign m_held_count    = count_reg;
    assign m_out_byte      = obyte_reg;
    assign m_byte_valid    = bvalid_reg;
    assign m_end_of_stream = eos_reg;

endmodule
`default_nettype wire

// File: src/btt_rem_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bit-serial remainder unit
// Restoring division, one dividend bit per cycle, MSB first. The dividend is
// left aligned, and the step count selects how many of its bits are used.
// ----------------------------------------------------------------------------
module btt_rem_unit
    import btt_pkg::*;
(
    input  wire            aclk,
    input  wire            aresetn,
    input  wire  div_req_t div_req,
    output div_rsp_t       div_rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [STEP_BITS-1:0] count_reg;
    logic [STOP_BITS-1:0] rem_reg;
    logic [STOP_BITS-1:0] divisor_reg;
    logic [DVD_BITS-1:0]  dvd_reg;

    logic [STOP_BITS:0]   trial;
    logic [STOP_BITS:0]   trial_sub;
    logic                 fits;

    // One restoring step: shift in the next dividend bit and subtract if it fits.
    assign trial     = {rem_reg, dvd_reg[DVD_BITS-1]};
    assign trial_sub = trial - {1'b0, divisor_reg};
    assign fits      = trial >= {1'b0, divisor_reg};

    // Step counter and completion pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (div_req.start) begin
                busy_reg  <= 1'b1;
                count_reg <= div_req.steps;
            end else if (busy_reg) begin
                count_reg <= count_reg - STEP_BITS'(1);
                if (count_reg == STEP_BITS'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and dividend shift register.
    always_ff @(posedge aclk) begin
        if (div_req.start) begin
            rem_reg     <= '0;
            dvd_reg     <= div_req.dividend;
            divisor_reg <= div_req.divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? trial_sub[STOP_BITS-1:0] : trial[STOP_BITS-1:0];
            dvd_reg <= {dvd_reg[DVD_BITS-2:0], 1'b0};
        end
    end

    assign div_rsp.done = done_reg;
    assign div_rsp.rem  = rem_reg;

endmodule
`default_nettype wire

// File: src/btt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Blank-run-to-tab converter port checker
// Watches the top level's ports and flags results and handshakes that the
// converter must never show.
// ----------------------------------------------------------------------------
module btt_checker
    import btt_pkg::*;
(
    input wire                 aclk,
    input wire                 aresetn,
    input wire                 s_valid,
    input wire                 s_ready,
    input wire                 m_valid,
    input wire                 m_ready,
    input wire                 m_lead_tab,
    input wire [HELD_BITS-1:0] m_held_count,
    input wire [BYTE_BITS-1:0] m_out_byte,
    input wire                 m_byte_valid,
    input wire                 m_end_of_stream
);

    // A stalled result stays and keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid
            && $stable({m_lead_tab, m_held_count, m_out_byte, m_byte_valid, m_end_of_stream}))
        else $error("result changed while stalled");

    // A result carries either a byte or the end of stream, and the end carries no byte.
    a_eos_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_end_of_stream != m_byte_valid)
            && (m_byte_valid || m_out_byte == CHAR_NUL))
        else $error("malformed end-of-stream result");

    // A request takes the sequencer out of idle, so s_ready drops after each acceptance.
    a_accept_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted on consecutive cycles");

    // A leading tab is part of the held run, so the run is not empty.
    a_lead_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_lead_tab |-> m_held_count != '0)
        else $error("leading tab with empty held run");

endmodule

bind blank_run_to_tab_converter btt_checker u_btt_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_lead_tab      (m_lead_tab),
    .m_held_count    (m_held_count),
    .m_out_byte      (m_out_byte),
    .m_byte_valid    (m_byte_valid),
    .m_end_of_stream (m_end_of_stream)
);
`default_nettype wire
